### sv/opcr_pkg.sv
// shared constants, codes and command/status types of the optical port contention resolver
package opcr_pkg;

    // channel table
    localparam int CHANNEL_COUNT = 65536;
    localparam int CH_W          = $clog2(CHANNEL_COUNT);
    localparam int ROW_BITS      = 32;
    localparam int BIT_W         = $clog2(ROW_BITS);
    localparam int ROWS          = (CHANNEL_COUNT + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_AW        = (ROWS > 1) ? $clog2(ROWS) : 1;

    // field widths
    localparam int RACK_W  = 16;
    localparam int TX_W    = 4;
    localparam int GRP_W   = 8;
    localparam int CNT_W   = 5;
    localparam int PORT_W  = 10;
    localparam int CHOUT_W = 16;

    // register widths
    localparam int FAB_W   = 8;
    localparam int AGG_W   = 7;
    localparam int TPR_W   = 5;
    localparam int GSZ_W   = 7;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 2;

    // arithmetic widths
    localparam int DIV_W     = 16;
    localparam int DIV_STEPS = 2;
    localparam int DIV_CYC   = DIV_W / DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_CYC);
    localparam int AT_W      = AGG_W + TPR_W;
    localparam int SPT_W     = AGG_W + TPR_W;
    localparam int PROD_W    = DIV_W + AT_W;
    localparam int CALC_W    = PROD_W + 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FABRIC_RADIX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGG_RADIX    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_PER_RACK  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE   = 2'd3;

    // request modes
    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // operand sets of the two dividers
    typedef enum logic [1:0] {
        DIV_MODSQ = 2'd0,
        DIV_MODA  = 2'd1,
        DIV_QUOT  = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_go;
        div_sel_t div_sel;
        logic     mul;
        logic     mem_rd;
        logic     mem_wr;
        logic     clear;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic clear_last;
    } ctrl_stat_t;

endpackage

### sv/opcr_div.sv
// iterative unsigned divider, two quotient bits per cycle
module opcr_div import opcr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient,
    output logic [DIV_W-1:0] remainder
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_W-1:0]     step_rem;
    logic [DIV_W-1:0]     step_quo;

    // restoring steps on the held partial remainder
    always_comb
    begin
        logic [DIV_W:0]   trial;
        logic [DIV_W-1:0] r;
        logic [DIV_W-1:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial = {r, q[DIV_W-1]};
            q     = {q[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial = trial - {1'b0, dvs_reg};
                q[0]  = 1'b1;
            end
            r = trial[DIV_W-1:0];
        end
        step_rem = r;
        step_quo = q;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = step_rem;
            quo_next = step_quo;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_CYC - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### sv/opcr_ctrl.sv
// sequencing state machine of the contention resolver
module opcr_ctrl import opcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       mode,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_PREP  = 9'b000000100,
        ST_MODSQ = 9'b000001000,
        ST_MODA  = 9'b000010000,
        ST_QUOT  = 9'b000100000,
        ST_MUL   = 9'b001000000,
        ST_MEMRD = 9'b010000000,
        ST_MEMWR = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_sel = DIV_MODSQ;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (mode == MODE_RELEASE) ? ST_MEMRD : ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = DIV_MODSQ;
                state_next  = ST_MODSQ;
            end
            ST_MODSQ:
            begin
                if (stat.div_done)
                begin
                    cmd.div_go  = 1'b1;
                    cmd.div_sel = DIV_MODA;
                    state_next  = ST_MODA;
                end
            end
            ST_MODA:
            begin
                if (stat.div_done)
                begin
                    cmd.div_go  = 1'b1;
                    cmd.div_sel = DIV_QUOT;
                    state_next  = ST_QUOT;
                end
            end
            ST_QUOT:
            begin
                if (stat.div_done)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_MEMRD;
            end
            ST_MEMRD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_MEMWR;
            end
            ST_MEMWR:
            begin
                cmd.mem_wr = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### sv/opcr_datapath.sv
// registers, dividers, port arithmetic and busy bitmap of the contention resolver
module opcr_datapath import opcr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 mode,
    input  logic [RACK_W-1:0]    src_rack,
    input  logic [RACK_W-1:0]    dst_rack,
    input  logic [TX_W-1:0]      tx_sel,
    input  logic [GRP_W-1:0]     group_sel,
    input  logic [CNT_W-1:0]     packet_count,
    input  logic [RACK_W-1:0]    release_channel,
    input  ctrl_cmd_t            cmd,
    output ctrl_stat_t           stat,
    output logic                 ack_valid,
    output logic [PORT_W-1:0]    ack_port,
    output logic [CHOUT_W-1:0]   channel_index,
    output logic                 retransmit,
    output logic [RACK_W-1:0]    ack_src_rack,
    output logic [RACK_W-1:0]    ack_dst_rack,
    output logic [TX_W-1:0]      ack_tx_sel,
    output logic [GRP_W-1:0]     ack_group_sel,
    output logic [CNT_W-1:0]     ack_packet_count,
    output logic                 index_overflow
);

    // configuration
    logic [FAB_W-1:0] fab_reg, fab_next;
    logic [AGG_W-1:0] agg_reg, agg_next;
    logic [TPR_W-1:0] tpr_reg, tpr_next;
    logic [GSZ_W-1:0] gsz_reg, gsz_next;

    // captured beat and derived constants
    logic              mode_reg;
    logic [RACK_W-1:0] src_reg;
    logic [RACK_W-1:0] dst_reg;
    logic [TX_W-1:0]   tx_reg;
    logic [GRP_W-1:0]  grp_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [RACK_W-1:0] rel_reg;
    logic [DIV_W-1:0]  sq_reg;
    logic [AGG_W-1:0]  a_reg;
    logic [GSZ_W-1:0]  g_reg;
    logic [TPR_W-1:0]  t_reg;
    logic [AT_W-1:0]   at_reg;
    logic [AGG_W-1:0]  a_eff;
    logic [GSZ_W-1:0]  g_eff;

    // divider operands and results
    logic [DIV_W-1:0] a_dvd, a_dvs, b_dvd, b_dvs;
    logic [DIV_W-1:0] quo_a, rem_a, quo_b, rem_b;
    logic             done_a, done_b;
    logic             sq_zero;

    // port arithmetic
    logic [AGG_W-1:0]  sp_reg, dp_reg, spg_reg;
    logic [SPT_W-1:0]  spt_reg, dpt_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [CALC_W-1:0] idx_next, idx_reg;
    logic              inrange_reg;
    logic [SPT_W-1:0]  in_port;

    // bitmap
    logic [ROW_BITS-1:0] busy_mem [ROWS];
    logic [ROW_BITS-1:0] rd_row_reg;
    logic [ROW_BITS-1:0] bit_mask;
    logic [ROW_AW-1:0]   clr_reg, clr_next;
    logic                mem_we;
    logic [ROW_AW-1:0]   mem_waddr;
    logic [ROW_BITS-1:0] mem_wdata;
    logic                bit_set;
    logic                deny;
    logic                valid_reg, valid_next;

    // result beat
    logic [PORT_W-1:0]  port_reg;
    logic [CHOUT_W-1:0] chout_reg;
    logic               retx_reg;
    logic [RACK_W-1:0]  asrc_reg, adst_reg;
    logic [TX_W-1:0]    atx_reg;
    logic [GRP_W-1:0]   agrp_reg;
    logic [CNT_W-1:0]   acnt_reg;
    logic               ovf_reg;

    // config writes
    always_comb
    begin
        fab_next = fab_reg;
        agg_next = agg_reg;
        tpr_next = tpr_reg;
        gsz_next = gsz_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FABRIC_RADIX: fab_next = cfg_data[FAB_W-1:0];
                CFG_AGG_RADIX:    agg_next = cfg_data[AGG_W-1:0];
                CFG_TX_PER_RACK:  tpr_next = cfg_data[TPR_W-1:0];
                CFG_GROUP_SIZE:   gsz_next = cfg_data[GSZ_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fab_reg <= FAB_W'(4);
            agg_reg <= AGG_W'(4);
            tpr_reg <= TPR_W'(1);
            gsz_reg <= GSZ_W'(1);
        end
        else
        begin
            fab_reg <= fab_next;
            agg_reg <= agg_next;
            tpr_reg <= tpr_next;
            gsz_reg <= gsz_next;
        end
    end

    // zero agg radix or group size counts as one
    assign a_eff = (agg_reg == '0) ? AGG_W'(1) : agg_reg;
    assign g_eff = (gsz_reg == '0) ? GSZ_W'(1) : gsz_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            src_reg  <= src_rack;
            dst_reg  <= dst_rack;
            tx_reg   <= tx_sel;
            grp_reg  <= group_sel;
            cnt_reg  <= packet_count;
            rel_reg  <= release_channel;
            sq_reg   <= DIV_W'(fab_reg) * DIV_W'(fab_reg);
            a_reg    <= a_eff;
            g_reg    <= g_eff;
            t_reg    <= tpr_reg;
            at_reg   <= AT_W'(a_eff) * AT_W'(tpr_reg);
        end
    end

    // zero square leaves the rack ids unreduced
    assign sq_zero = (sq_reg == '0);

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_MODSQ:
            begin
                a_dvd = src_reg;
                a_dvs = sq_reg;
                b_dvd = dst_reg;
                b_dvs = sq_reg;
            end
            DIV_MODA:
            begin
                a_dvd = sq_zero ? src_reg : rem_a;
                a_dvs = DIV_W'(a_reg);
                b_dvd = sq_zero ? dst_reg : rem_b;
                b_dvs = DIV_W'(a_reg);
            end
            DIV_QUOT:
            begin
                a_dvd = src_reg;
                a_dvs = DIV_W'(a_reg);
                b_dvd = DIV_W'(rem_a[AGG_W-1:0]);
                b_dvs = DIV_W'(g_reg);
            end
            default:
            begin
                a_dvd = src_reg;
                a_dvs = sq_reg;
                b_dvd = dst_reg;
                b_dvs = sq_reg;
            end
        endcase
    end

    opcr_div u_div_a
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (cmd.div_go),
        .dividend  (a_dvd),
        .divisor   (a_dvs),
        .done      (done_a),
        .quotient  (quo_a),
        .remainder (rem_a)
    );

    opcr_div u_div_b
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (cmd.div_go),
        .dividend  (b_dvd),
        .divisor   (b_dvs),
        .done      (done_b),
        .quotient  (quo_b),
        .remainder (rem_b)
    );

    // rack positions inside the aggregation switch
    always_ff @(posedge clk)
    begin
        if (cmd.div_go && (cmd.div_sel == DIV_QUOT))
        begin
            sp_reg <= rem_a[AGG_W-1:0];
            dp_reg <= rem_b[AGG_W-1:0];
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(quo_a) * PROD_W'(at_reg);
            spt_reg  <= SPT_W'(sp_reg) * SPT_W'(t_reg);
            dpt_reg  <= SPT_W'(dp_reg) * SPT_W'(t_reg);
            spg_reg  <= quo_b[AGG_W-1:0];
        end
    end

    // channel index of a request, or the channel of a release
    assign idx_next = (mode_reg == MODE_RELEASE)
                    ? CALC_W'(rel_reg)
                    : CALC_W'(prod_reg) + CALC_W'(dpt_reg) + CALC_W'(spg_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
        begin
            idx_reg     <= idx_next;
            inrange_reg <= (idx_next < CALC_W'(CHANNEL_COUNT));
        end
    end

    assign bit_mask = ROW_BITS'(1) << idx_reg[BIT_W-1:0];
    assign bit_set  = rd_row_reg[idx_reg[BIT_W-1:0]];
    assign deny     = !inrange_reg || bit_set;
    assign in_port  = spt_reg + SPT_W'(tx_reg);

    // clearing pass after reset
    assign clr_next = cmd.clear ? (clr_reg + 1'b1) : clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else
            clr_reg <= clr_next;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg[CH_W-1:BIT_W];
        mem_wdata = rd_row_reg | bit_mask;
        if (cmd.clear)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if (cmd.mem_wr)
        begin
            if (mode_reg == MODE_RELEASE)
            begin
                mem_we    = inrange_reg;
                mem_wdata = rd_row_reg & ~bit_mask;
            end
            else
            begin
                mem_we    = !deny;
                mem_wdata = rd_row_reg | bit_mask;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            busy_mem[mem_waddr] <= mem_wdata;
        if (cmd.mem_rd)
            rd_row_reg <= busy_mem[idx_next[CH_W-1:BIT_W]];
    end

    // result beat
    assign valid_next = cmd.mem_wr && (mode_reg == MODE_REQUEST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (valid_next)
        begin
            port_reg  <= in_port[PORT_W-1:0];
            chout_reg <= idx_reg[CHOUT_W-1:0];
            retx_reg  <= deny;
            asrc_reg  <= src_reg;
            adst_reg  <= dst_reg;
            atx_reg   <= tx_reg;
            agrp_reg  <= grp_reg;
            acnt_reg  <= cnt_reg;
            ovf_reg   <= !inrange_reg;
        end
    end

    assign stat.div_done   = done_a && done_b;
    assign stat.clear_last = (clr_reg == ROW_AW'(ROWS - 1));

    assign ack_valid        = valid_reg;
    assign ack_port         = port_reg;
    assign channel_index    = chout_reg;
    assign retransmit       = retx_reg;
    assign ack_src_rack     = asrc_reg;
    assign ack_dst_rack     = adst_reg;
    assign ack_tx_sel       = atx_reg;
    assign ack_group_sel    = agrp_reg;
    assign ack_packet_count = acnt_reg;
    assign index_overflow   = ovf_reg;

endmodule

### sv/optical_port_contention_resolver.sv
// top level of the optical port contention resolver
//
//   channel   ports                                        beat taken when
//   -------   -------------------------------------------  ------------------------
//   config    cfg_we, cfg_index, cfg_data                  cfg_we high
//   request   start, busy, mode, src_rack .. release_chan  start high, busy low
//   ack       ack_valid, ack_port .. index_overflow        ack_valid high, one cycle
//
// between its accept edge and the edge that takes its ack, a request goes through
// a setup step, then three rounds of the two iterative dividers, each round
// stepping 2 quotient bits at a time up to its done: src and dst mod fabric_radix
// squared, then mod agg_radix, then src / agg_radix and port / group_size; then
// a multiply step, a bitmap row read, a row write and the ack cycle
// a release goes through accept, bitmap row read and row write
// after reset the bitmap is cleared one 32-bit row a cycle over all ROWS rows (2048),
// with busy high; config writes are taken during the pass
// the ack beat is strobed for one cycle and the receiver cannot stall it; the
// next request may be accepted in the same cycle as the strobe
module optical_port_contention_resolver import opcr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // config write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    // request beat
    input  logic                 start,
    output logic                 busy,
    input  logic                 mode,
    input  logic [RACK_W-1:0]    src_rack,
    input  logic [RACK_W-1:0]    dst_rack,
    input  logic [TX_W-1:0]      tx_sel,
    input  logic [GRP_W-1:0]     group_sel,
    input  logic [CNT_W-1:0]     packet_count,
    input  logic [RACK_W-1:0]    release_channel,

    // acknowledge beat
    output logic                 ack_valid,
    output logic [PORT_W-1:0]    ack_port,
    output logic [CHOUT_W-1:0]   channel_index,
    output logic                 retransmit,
    output logic [RACK_W-1:0]    ack_src_rack,
    output logic [RACK_W-1:0]    ack_dst_rack,
    output logic [TX_W-1:0]      ack_tx_sel,
    output logic [GRP_W-1:0]     ack_group_sel,
    output logic [CNT_W-1:0]     ack_packet_count,
    output logic                 index_overflow
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // sequencer: clear pass, divider rounds, multiply, bitmap update
    opcr_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // config registers, dividers, port math, busy bitmap and ack register
    opcr_datapath u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mode             (mode),
        .src_rack         (src_rack),
        .dst_rack         (dst_rack),
        .tx_sel           (tx_sel),
        .group_sel        (group_sel),
        .packet_count     (packet_count),
        .release_channel  (release_channel),
        .cmd              (cmd),
        .stat             (stat),
        .ack_valid        (ack_valid),
        .ack_port         (ack_port),
        .channel_index    (channel_index),
        .retransmit       (retransmit),
        .ack_src_rack     (ack_src_rack),
        .ack_dst_rack     (ack_dst_rack),
        .ack_tx_sel       (ack_tx_sel),
        .ack_group_sel    (ack_group_sel),
        .ack_packet_count (ack_packet_count),
        .index_overflow   (index_overflow)
    );

`ifndef NO_ASSERTIONS
    // an accepted beat always leaves the block working in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after an accepted beat");

    // an ack beat only comes out of a finished bitmap update
    a_ack_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        ack_valid |-> $past(busy))
        else $error("ack beat without preceding work");

    // a release never produces an ack beat
    a_release_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode) |=> !ack_valid ##1 !ack_valid ##1 !ack_valid)
        else $error("ack beat after a release");

    // an index beyond the table is never granted
    a_overflow_denied: assert property (@(posedge clk) disable iff (!rst_n)
        (ack_valid && index_overflow) |-> retransmit)
        else $error("overflowing channel index granted");
`endif

endmodule
